// ===== rtl/nbg_pkg.sv =====
// ---------------------------------------------------------------------------
// nbg_pkg: shared types and constants of the n-body gravity engine
// Payload structs, controller states, command and status groups, and the
// saturation helper used by the update datapath.
// ---------------------------------------------------------------------------
package nbg_pkg;

  // fixed geometry of the body store and the fields
  localparam int IDX_W          = 6;
  localparam int SLOTS          = 64;
  localparam int CNT_W          = 7;
  localparam int WORD_W         = 32;
  localparam int DIVA_W         = 64;
  localparam int R_W            = 33;
  localparam int Q_W            = 41;
  localparam int ACC_W          = 48;
  localparam int HALF_W         = 21;
  localparam int DEF_MAX_BODIES = 64;
  localparam int DEF_FRAC_BITS  = 16;

  // quotient and force-term ceiling, 2^40
  localparam logic [Q_W-1:0] Q_CAP = 41'h100_0000_0000;

  // register reset values
  localparam logic [31:0] RST_GRAV  = 32'd65536;
  localparam logic [6:0]  RST_COUNT = 7'd64;
  localparam logic [15:0] RST_STEP  = 16'd3277;
  localparam logic [15:0] RST_MIND  = 16'd1;

  typedef enum logic [1:0] {
    CFG_GRAV  = 2'd0,
    CFG_COUNT = 2'd1,
    CFG_STEP  = 2'd2,
    CFG_MIND  = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [IDX_W-1:0]   body_index;
    logic [31:0]        mass;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]   out_index;
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic               last;
  } out_item_t;

  typedef enum logic [1:0] {
    DIV_K  = 2'd0,
    DIV_G1 = 2'd1,
    DIV_UX = 2'd2,
    DIV_UY = 2'd3
  } div_sel_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_A_RDI, ST_A_CAPI, ST_A_JCHK, ST_A_PREP, ST_A_SQX, ST_A_SQY,
    ST_A_SQRT, ST_A_SQRTW, ST_A_RFIX, ST_A_D1, ST_A_D1W, ST_A_D2, ST_A_D2W,
    ST_A_DX, ST_A_DXW, ST_A_MX, ST_A_MXW, ST_A_ADDX, ST_A_DY, ST_A_DYW,
    ST_A_MY, ST_A_MYW, ST_A_ADDY, ST_A_WR, ST_U_RD, ST_U_WR, ST_C_RDI,
    ST_C_CAPI, ST_C_RDJ, ST_C_CMP, ST_C_RVI, ST_C_CAPVI, ST_C_SWI, ST_C_SWJ,
    ST_E_RD, ST_E_LD, ST_E_W
  } state_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] addr;
    logic             load_wr;
    logic             cap_pi;
    logic             acc_clr;
    logic             pair_prep;
    logic             sq_x;
    logic             sq_y;
    logic             sqrt_start;
    logic             r_fix;
    logic             div_start;
    div_sel_t         div_sel;
    logic             mul_start;
    logic             add_x;
    logic             add_y;
    logic             acc_wr;
    logic             upd_wr;
    logic             cap_vi;
    logic             swap_i;
    logic             swap_j;
    logic             out_load;
    logic             out_last;
  } cmd_t;

  typedef struct packed {
    logic             div_done;
    logic             sqrt_done;
    logic             mul_done;
    logic             pos_eq;
    logic             out_fire;
    logic [CNT_W-1:0] body_count;
  } sts_t;

  // clamp a wide signed value to 32 bits signed
  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [49:0] hi;
    logic signed [49:0] lo;
    hi = 50'sh7FFF_FFFF;
    lo = -50'sh8000_0000;
    if (v > hi) return 32'sh7FFF_FFFF;
    else if (v < lo) return 32'sh8000_0000;
    else return v[31:0];
  endfunction

endpackage

// ===== rtl/nbg_div.sv =====
// ---------------------------------------------------------------------------
// nbg_div: serial fixed-point divider
// Returns floor(a * 2^FRAC_BITS / b) capped at 2^40, one quotient bit a cycle.
// ---------------------------------------------------------------------------
module nbg_div #(
  parameter int FRAC_BITS = nbg_pkg::DEF_FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [nbg_pkg::DIVA_W-1:0] a,
  input  logic [nbg_pkg::R_W-1:0]  b,
  output logic                     done,
  output logic [nbg_pkg::Q_W-1:0]  q
);
  import nbg_pkg::*;

  localparam int NUM_W  = DIVA_W + FRAC_BITS;
  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  num;
  logic [R_W-1:0]    rem;
  logic [R_W-1:0]    dvs;
  logic [Q_W-1:0]    quo;
  logic              ovf;
  logic              busy;
  logic [STEP_W-1:0] cnt;
  logic [R_W:0]      trial;
  logic              qbit;

  // one restoring step
  always_comb begin
    trial = {rem, num[NUM_W-1]};
    qbit  = (trial >= {1'b0, dvs});
  end

  // control of the iteration
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == STEP_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shifting numerator, remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      num <= {a, {FRAC_BITS{1'b0}}};
      dvs <= b;
      rem <= '0;
      quo <= '0;
      ovf <= 1'b0;
    end else if (busy) begin
      num <= {num[NUM_W-2:0], 1'b0};
      rem <= qbit ? R_W'(trial - {1'b0, dvs}) : trial[R_W-1:0];
      quo <= {quo[Q_W-2:0], qbit};
      ovf <= ovf | quo[Q_W-1];
    end
  end

  // saturated result
  assign q = (ovf || (quo[Q_W-1] && (|quo[Q_W-2:0]))) ? Q_CAP : quo;

endmodule

// ===== rtl/nbg_dp.sv =====
// ---------------------------------------------------------------------------
// nbg_dp: datapath of the n-body engine
// Body stores, configuration registers, pair force arithmetic with serial
// square root, divider and multiplier, Euler update and the result register.
// ---------------------------------------------------------------------------
module nbg_dp #(
  parameter int FRAC_BITS = nbg_pkg::DEF_FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  nbg_pkg::cmd_t       cmd,
  output nbg_pkg::sts_t       sts,
  input  nbg_pkg::in_item_t   in_data,
  input  logic                cfg_we,
  input  nbg_pkg::cfg_idx_t   cfg_index,
  input  logic [31:0]         cfg_data,
  output logic                out_valid,
  input  logic                out_stall,
  output nbg_pkg::out_item_t  out_data
);
  import nbg_pkg::*;

  // configuration
  logic [31:0]      grav;
  logic [CNT_W-1:0] bcount;
  logic [15:0]      dt;
  logic [15:0]      mind;

  // body stores
  logic [31:0]        mem_m  [SLOTS];
  logic signed [31:0] mem_px [SLOTS];
  logic signed [31:0] mem_py [SLOTS];
  logic signed [31:0] mem_vx [SLOTS];
  logic signed [31:0] mem_vy [SLOTS];
  logic signed [31:0] mem_ax [SLOTS];
  logic signed [31:0] mem_ay [SLOTS];

  logic [31:0]        rd_m;
  logic signed [31:0] rd_px, rd_py, rd_vx, rd_vy, rd_ax, rd_ay;

  // pair registers
  logic signed [31:0] pix, piy, vix, viy;
  logic               sign_x, sign_y, shr;
  logic [32:0]        mag_x, mag_y;
  logic [63:0]        kval;
  logic [61:0]        sq_x;
  logic [63:0]        rad;
  logic [R_W-1:0]     rval;
  logic [Q_W-1:0]     g1, gval, uval;
  logic signed [ACC_W-1:0] acc_x, acc_y;

  // square root unit
  logic [63:0] sq_v, sq_res, sq_bit;
  logic [4:0]  sq_cnt;
  logic        sq_busy, sq_done;
  logic [63:0] sq_sum;

  // multiplier sequencer
  logic [1:0]  mcnt;
  logic        mbusy, mdone;
  logic [81:0] prod;
  logic [HALF_W-1:0] ga, ub;
  logic [2*HALF_W-1:0] pp;
  logic [6:0]  msh;

  // divider hookup
  div_sel_t        dsel;
  logic [63:0]     div_a;
  logic            div_done;
  logic [Q_W-1:0]  div_q;

  // combinational helpers
  logic signed [32:0] dx, dy;
  logic [32:0]        ax_m, ay_m;
  logic [30:0]        ax_s, ay_s;
  logic [R_W-1:0]     r0, rmin;
  logic [81:0]        tq;
  logic [Q_W-1:0]     tcap;
  logic signed [ACC_W-1:0] tpos;
  logic signed [48:0] pvx, pvy, avx, avy;
  logic signed [31:0] upd_px, upd_py, upd_vx, upd_vy;
  logic signed [31:0] acc_sx, acc_sy;
  logic [IDX_W-1:0]   wa;
  logic               out_fire;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      grav   <= RST_GRAV;
      bcount <= RST_COUNT;
      dt     <= RST_STEP;
      mind   <= RST_MIND;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRAV:  grav   <= cfg_data;
        CFG_COUNT: bcount <= cfg_data[CNT_W-1:0];
        CFG_STEP:  dt     <= cfg_data[15:0];
        CFG_MIND:  mind   <= cfg_data[15:0];
      endcase
    end
  end

  // pair differences and shifted magnitudes
  always_comb begin
    dx   = 33'(rd_px) - 33'(pix);
    dy   = 33'(rd_py) - 33'(piy);
    ax_m = dx[32] ? 33'(-dx) : 33'(dx);
    ay_m = dy[32] ? 33'(-dy) : 33'(dy);
    ax_s = shr ? mag_x[31:1] : mag_x[30:0];
    ay_s = shr ? mag_y[31:1] : mag_y[30:0];
    rmin = (mind == 16'd0) ? R_W'(1) : R_W'(mind);
    r0   = shr ? {sq_res[31:0], 1'b0} : {1'b0, sq_res[31:0]};
  end

  // euler update and accumulator clamp
  always_comb begin
    pvx    = rd_vx * $signed({1'b0, dt});
    pvy    = rd_vy * $signed({1'b0, dt});
    avx    = rd_ax * $signed({1'b0, dt});
    avy    = rd_ay * $signed({1'b0, dt});
    upd_px = sat32(50'(rd_px) + 50'(pvx >>> FRAC_BITS));
    upd_py = sat32(50'(rd_py) + 50'(pvy >>> FRAC_BITS));
    upd_vx = sat32(50'(rd_vx) + 50'(avx >>> FRAC_BITS));
    upd_vy = sat32(50'(rd_vy) + 50'(avy >>> FRAC_BITS));
    acc_sx = sat32(50'(acc_x));
    acc_sy = sat32(50'(acc_y));
  end

  // force term magnitude from the product
  always_comb begin
    tq   = prod >> FRAC_BITS;
    tcap = (tq > 82'(Q_CAP)) ? Q_CAP : tq[Q_W-1:0];
    tpos = ACC_W'(tcap);
  end

  // store writes
  assign wa = cmd.load_wr ? in_data.body_index : cmd.addr;

  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      mem_m[wa]  <= in_data.mass;
      mem_px[wa] <= in_data.pos_x;
      mem_py[wa] <= in_data.pos_y;
      mem_vx[wa] <= in_data.vel_x;
      mem_vy[wa] <= in_data.vel_y;
    end else if (cmd.upd_wr) begin
      mem_px[wa] <= upd_px;
      mem_py[wa] <= upd_py;
      mem_vx[wa] <= upd_vx;
      mem_vy[wa] <= upd_vy;
    end else if (cmd.swap_i) begin
      mem_vx[wa] <= rd_vx;
      mem_vy[wa] <= rd_vy;
    end else if (cmd.swap_j) begin
      mem_vx[wa] <= vix;
      mem_vy[wa] <= viy;
    end
    if (cmd.acc_wr) begin
      mem_ax[wa] <= acc_sx;
      mem_ay[wa] <= acc_sy;
    end
  end

  // registered store reads
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_m  <= mem_m[cmd.addr];
      rd_px <= mem_px[cmd.addr];
      rd_py <= mem_py[cmd.addr];
      rd_vx <= mem_vx[cmd.addr];
      rd_vy <= mem_vy[cmd.addr];
      rd_ax <= mem_ax[cmd.addr];
      rd_ay <= mem_ay[cmd.addr];
    end
  end

  // pair setup, squares, radius and accumulation
  always_ff @(posedge clk) begin
    if (cmd.cap_pi) begin
      pix <= rd_px;
      piy <= rd_py;
    end
    if (cmd.cap_vi) begin
      vix <= rd_vx;
      viy <= rd_vy;
    end
    if (cmd.pair_prep) begin
      sign_x <= dx[32];
      sign_y <= dy[32];
      mag_x  <= ax_m;
      mag_y  <= ay_m;
      shr    <= ax_m[32] | ax_m[31] | ay_m[32] | ay_m[31];
      kval   <= (64'(grav) * 64'(rd_m)) >> FRAC_BITS;
    end
    if (cmd.sq_x) sq_x <= ax_s * ax_s;
    if (cmd.sq_y) rad <= 64'(sq_x) + 64'(ay_s * ay_s);
    if (cmd.r_fix) rval <= (r0 < rmin) ? rmin : r0;
    if (cmd.acc_clr) begin
      acc_x <= '0;
      acc_y <= '0;
    end else if (cmd.add_x) begin
      acc_x <= acc_x + (sign_x ? -tpos : tpos);
    end else if (cmd.add_y) begin
      acc_y <= acc_y + (sign_y ? -tpos : tpos);
    end
  end

  // serial integer square root, two radicand bits a cycle
  assign sq_sum = sq_res + sq_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_busy <= 1'b0;
      sq_done <= 1'b0;
      sq_cnt  <= '0;
    end else begin
      sq_done <= 1'b0;
      if (cmd.sqrt_start) begin
        sq_busy <= 1'b1;
        sq_cnt  <= '0;
      end else if (sq_busy) begin
        sq_cnt <= sq_cnt + 1'b1;
        if (sq_cnt == 5'd31) begin
          sq_busy <= 1'b0;
          sq_done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      sq_v   <= rad;
      sq_res <= '0;
      sq_bit <= 64'h4000_0000_0000_0000;
    end else if (sq_busy) begin
      if (sq_v >= sq_sum) begin
        sq_v   <= sq_v - sq_sum;
        sq_res <= (sq_res >> 1) + sq_bit;
      end else begin
        sq_res <= sq_res >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
  end

  // divider operands and result routing
  always_comb begin
    unique case (cmd.div_sel)
      DIV_K:  div_a = kval;
      DIV_G1: div_a = 64'(g1);
      DIV_UX: div_a = 64'(mag_x);
      DIV_UY: div_a = 64'(mag_y);
    endcase
  end

  nbg_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .a     (div_a),
    .b     (rval),
    .done  (div_done),
    .q     (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_start) dsel <= cmd.div_sel;
    if (div_done) begin
      unique case (dsel)
        DIV_K:  g1   <= div_q;
        DIV_G1: gval <= div_q;
        DIV_UX: uval <= div_q;
        DIV_UY: uval <= div_q;
      endcase
    end
  end

  // 41 by 41 product as four half-word partial products
  always_comb begin
    ga  = mcnt[0] ? HALF_W'(gval[Q_W-1:HALF_W]) : gval[HALF_W-1:0];
    ub  = mcnt[1] ? HALF_W'(uval[Q_W-1:HALF_W]) : uval[HALF_W-1:0];
    pp  = ga * ub;
    msh = (mcnt[0] & mcnt[1]) ? 7'(2 * HALF_W) :
          (mcnt[0] | mcnt[1]) ? 7'(HALF_W) : 7'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy <= 1'b0;
      mdone <= 1'b0;
      mcnt  <= '0;
    end else begin
      mdone <= 1'b0;
      if (cmd.mul_start) begin
        mbusy <= 1'b1;
        mcnt  <= '0;
      end else if (mbusy) begin
        mcnt <= mcnt + 1'b1;
        if (mcnt == 2'd3) begin
          mbusy <= 1'b0;
          mdone <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_start) prod <= '0;
    else if (mbusy) prod <= prod + (82'(pp) << msh);
  end

  // result register
  assign out_fire = out_valid & ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.out_index <= cmd.addr;
      out_data.new_pos_x <= rd_px;
      out_data.new_pos_y <= rd_py;
      out_data.new_vel_x <= rd_vx;
      out_data.new_vel_y <= rd_vy;
      out_data.last      <= cmd.out_last;
    end
  end

  // status back to the controller
  always_comb begin
    sts.div_done   = div_done;
    sts.sqrt_done  = sq_done;
    sts.mul_done   = mdone;
    sts.pos_eq     = (rd_px == pix) && (rd_py == piy);
    sts.out_fire   = out_fire;
    sts.body_count = bcount;
  end

endmodule

// ===== rtl/nbg_ctrl.sv =====
// ---------------------------------------------------------------------------
// nbg_ctrl: sequencer of the n-body engine
// Walks loads, the force pass over all ordered pairs, the update pass, the
// coincidence pass and the report, issuing datapath commands.
// ---------------------------------------------------------------------------
module nbg_ctrl #(
  parameter int MAX_BODIES = nbg_pkg::DEF_MAX_BODIES
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  nbg_pkg::op_t               in_op,
  input  logic [nbg_pkg::IDX_W-1:0]  in_index,
  output logic                       in_stall,
  input  nbg_pkg::sts_t              sts,
  output nbg_pkg::cmd_t              cmd
);
  import nbg_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] i, j, n, n_in;
  logic             step_go, i_end, j_end, i2_end;

  // bodies in use, clamped to the build size
  assign n_in    = (sts.body_count > CNT_W'(MAX_BODIES)) ? CNT_W'(MAX_BODIES)
                                                          : sts.body_count;
  assign step_go = (state == ST_IDLE) && in_valid && (in_op == OP_STEP);
  assign i_end   = (i + 1'b1) == n;
  assign j_end   = (j + 1'b1) == n;
  assign i2_end  = (i + CNT_W'(2)) == n;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (step_go && n_in != '0) state_next = ST_A_RDI;
      ST_A_RDI:   state_next = ST_A_CAPI;
      ST_A_CAPI:  state_next = ST_A_JCHK;
      ST_A_JCHK: begin
        if (j == n) state_next = ST_A_WR;
        else if (j != i) state_next = ST_A_PREP;
      end
      ST_A_PREP:  state_next = ST_A_SQX;
      ST_A_SQX:   state_next = ST_A_SQY;
      ST_A_SQY:   state_next = ST_A_SQRT;
      ST_A_SQRT:  state_next = ST_A_SQRTW;
      ST_A_SQRTW: if (sts.sqrt_done) state_next = ST_A_RFIX;
      ST_A_RFIX:  state_next = ST_A_D1;
      ST_A_D1:    state_next = ST_A_D1W;
      ST_A_D1W:   if (sts.div_done) state_next = ST_A_D2;
      ST_A_D2:    state_next = ST_A_D2W;
      ST_A_D2W:   if (sts.div_done) state_next = ST_A_DX;
      ST_A_DX:    state_next = ST_A_DXW;
      ST_A_DXW:   if (sts.div_done) state_next = ST_A_MX;
      ST_A_MX:    state_next = ST_A_MXW;
      ST_A_MXW:   if (sts.mul_done) state_next = ST_A_ADDX;
      ST_A_ADDX:  state_next = ST_A_DY;
      ST_A_DY:    state_next = ST_A_DYW;
      ST_A_DYW:   if (sts.div_done) state_next = ST_A_MY;
      ST_A_MY:    state_next = ST_A_MYW;
      ST_A_MYW:   if (sts.mul_done) state_next = ST_A_ADDY;
      ST_A_ADDY:  state_next = ST_A_JCHK;
      ST_A_WR:    state_next = i_end ? ST_U_RD : ST_A_RDI;
      ST_U_RD:    state_next = ST_U_WR;
      ST_U_WR: begin
        if (!i_end) state_next = ST_U_RD;
        else if (n < CNT_W'(2)) state_next = ST_E_RD;
        else state_next = ST_C_RDI;
      end
      ST_C_RDI:   state_next = ST_C_CAPI;
      ST_C_CAPI:  state_next = ST_C_RDJ;
      ST_C_RDJ:   state_next = ST_C_CMP;
      ST_C_CMP: begin
        if (sts.pos_eq) state_next = ST_C_RVI;
        else if (!j_end) state_next = ST_C_RDJ;
        else state_next = i2_end ? ST_E_RD : ST_C_RDI;
      end
      ST_C_RVI:   state_next = ST_C_CAPVI;
      ST_C_CAPVI: state_next = ST_C_SWI;
      ST_C_SWI:   state_next = ST_C_SWJ;
      ST_C_SWJ: begin
        if (!j_end) state_next = ST_C_RDJ;
        else state_next = i2_end ? ST_E_RD : ST_C_RDI;
      end
      ST_E_RD:    state_next = ST_E_LD;
      ST_E_LD:    state_next = ST_E_W;
      ST_E_W:     if (sts.out_fire) state_next = i_end ? ST_IDLE : ST_E_RD;
      default:    state_next = ST_IDLE;
    endcase
  end

  // loop counters
  always_ff @(posedge clk) begin
    if (rst) begin
      i <= '0;
      j <= '0;
      n <= '0;
    end else begin
      unique case (state)
        ST_IDLE: if (step_go) begin
          n <= n_in;
          i <= '0;
          j <= '0;
        end
        ST_A_CAPI: j <= '0;
        ST_A_JCHK: if (j != n && j == i) j <= j + 1'b1;
        ST_A_ADDY: j <= j + 1'b1;
        ST_A_WR, ST_U_WR: i <= i_end ? '0 : i + 1'b1;
        ST_C_CAPI: j <= i + 1'b1;
        ST_C_CMP, ST_C_SWJ: begin
          if ((state == ST_C_SWJ) || !sts.pos_eq) begin
            if (!j_end) j <= j + 1'b1;
            else i <= i2_end ? '0 : i + 1'b1;
          end
        end
        ST_E_W: if (sts.out_fire && !i_end) i <= i + 1'b1;
        default: ;
      endcase
    end
  end

  // datapath commands
  always_comb begin
    cmd      = '0;
    cmd.addr = i[IDX_W-1:0];
    in_stall = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: cmd.load_wr = in_valid && (in_op == OP_LOAD) &&
                             (CNT_W'(in_index) < CNT_W'(MAX_BODIES));
      ST_A_RDI: cmd.rd_en = 1'b1;
      ST_A_CAPI: begin
        cmd.cap_pi  = 1'b1;
        cmd.acc_clr = 1'b1;
      end
      ST_A_JCHK: begin
        cmd.addr  = j[IDX_W-1:0];
        cmd.rd_en = (j != n) && (j != i);
      end
      ST_A_PREP: cmd.pair_prep  = 1'b1;
      ST_A_SQX:  cmd.sq_x       = 1'b1;
      ST_A_SQY:  cmd.sq_y       = 1'b1;
      ST_A_SQRT: cmd.sqrt_start = 1'b1;
      ST_A_RFIX: cmd.r_fix      = 1'b1;
      ST_A_D1: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_K;
      end
      ST_A_D2: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_G1;
      end
      ST_A_DX: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_UX;
      end
      ST_A_DY: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_UY;
      end
      ST_A_MX, ST_A_MY: cmd.mul_start = 1'b1;
      ST_A_ADDX: cmd.add_x  = 1'b1;
      ST_A_ADDY: cmd.add_y  = 1'b1;
      ST_A_WR:   cmd.acc_wr = 1'b1;
      ST_U_RD, ST_C_RDI, ST_C_RVI, ST_E_RD: cmd.rd_en = 1'b1;
      ST_U_WR:   cmd.upd_wr = 1'b1;
      ST_C_CAPI: cmd.cap_pi = 1'b1;
      ST_C_RDJ: begin
        cmd.addr  = j[IDX_W-1:0];
        cmd.rd_en = 1'b1;
      end
      ST_C_CAPVI: begin
        cmd.cap_vi = 1'b1;
        cmd.addr   = j[IDX_W-1:0];
        cmd.rd_en  = 1'b1;
      end
      ST_C_SWI: cmd.swap_i = 1'b1;
      ST_C_SWJ: begin
        cmd.addr   = j[IDX_W-1:0];
        cmd.swap_j = 1'b1;
      end
      ST_E_LD: begin
        cmd.out_load = 1'b1;
        cmd.out_last = i_end;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/nbody_gravity_euler_step_top.sv =====
// ---------------------------------------------------------------------------
// nbody_gravity_euler_step_top: 2-d gravitational n-body engine, euler step
// Loads bodies into on-chip stores and, on a step, integrates all bodies
// once and reports each body's new state.
//
//   channel  direction  handshake             beat
//   in       sink       in_valid / in_stall   in_data (load or step)
//   out      source     out_valid / out_stall out_data (one body state)
//   cfg      sink       cfg_we                cfg_index, cfg_data
//
// A load is written to the stores as it is taken. A step of n bodies is
// dominated by the serial divider, which does four divisions per ordered
// pair, followed by the update pass, the coincidence check of each pair
// i<j, which swaps the pair's velocities when the pair coincides, and the
// report of each body.
// in_stall is high from the step until its last body beat is taken.
// Reset is synchronous, clears control and restores the configuration
// defaults; the stores hold nothing defined until bodies are loaded.
// out_stall only holds the current body beat.
// ---------------------------------------------------------------------------
module nbody_gravity_euler_step_top #(
  parameter int MAX_BODIES = nbg_pkg::DEF_MAX_BODIES,
  parameter int FRAC_BITS  = nbg_pkg::DEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  nbg_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output nbg_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  nbg_pkg::cfg_idx_t  cfg_index,
  input  logic [31:0]        cfg_data
);
  import nbg_pkg::*;

  cmd_t cmd;
  sts_t sts;

  nbg_ctrl #(.MAX_BODIES(MAX_BODIES)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .in_index (in_data.body_index),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  nbg_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/nbg_chk.sv =====
// ---------------------------------------------------------------------------
// nbg_chk: port checker of the n-body engine
// Watches the top-level ports for handshake and sequencing slips.
// ---------------------------------------------------------------------------
module nbg_chk (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input nbg_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input nbg_pkg::out_item_t out_data
);
  import nbg_pkg::*;

  // a stalled input beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input beat changed while stalled");

  // a stalled body beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("body beat changed while stalled");

  // no body beat right after reset
  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("body beat after reset");

  // no new item is taken while a report is running
  a_busy_report: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open during report");

  // the last body beat frees the input
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && out_data.last |=> !in_stall && !out_valid)
    else $error("input still held after last body beat");

endmodule

bind nbody_gravity_euler_step_top nbg_chk u_chk (.*);
